>>> sv/keyed_entry_table_assert.svh
// ------------------------------------------------------------------------
// keyed_entry_table_assert.svh
// assertion shorthands used by the keyed entry table top module
// ------------------------------------------------------------------------
`ifndef KEYED_ENTRY_TABLE_ASSERT_SVH
`define KEYED_ENTRY_TABLE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define KET_CHECK_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define KET_CHECK_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/ket_pkg.sv
// ------------------------------------------------------------------------
// ket_pkg
// shared types and codes of the keyed entry table
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ket_pkg;

	localparam int KEY_W = 24;
	localparam int SEG_W = 16;

	typedef logic [KEY_W-1:0] key_t;
	typedef logic [SEG_W-1:0] seg_t;
	typedef logic [2:0] req_t;
	typedef logic [1:0] stat_t;

	localparam req_t REQ_ADD    = 3'd0;
	localparam req_t REQ_DELETE = 3'd1;
	localparam req_t REQ_SET    = 3'd2;
	localparam req_t REQ_LOOKUP = 3'd3;
	localparam req_t REQ_READ   = 3'd4;

	localparam stat_t STAT_DONE = 2'd0;
	localparam stat_t STAT_DUP  = 2'd1;
	localparam stat_t STAT_FULL = 2'd2;
	localparam stat_t STAT_MISS = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MATCH,
		S_EXEC
	} state_t;

	// per-cell control from the sequencer
	typedef struct packed {
		logic match_en;
		logic by_slot;
		logic live;
		logic is_slot;
		logic wr_new;
		logic wr_seg;
		logic shift;
	} cell_ctl_t;

endpackage

`default_nettype wire

>>> sv/ket_cell.sv
// ------------------------------------------------------------------------
// ket_cell
// one table slot: holds key and segment, flags a match, loads from the
// next slot up when the table compacts
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ket_cell (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire ket_pkg::cell_ctl_t ctl,
	input  wire ket_pkg::key_t      req_key,
	input  wire ket_pkg::seg_t      req_seg,
	input  wire ket_pkg::key_t      nb_key,
	input  wire ket_pkg::seg_t      nb_seg,
	output ket_pkg::key_t           entry_key,
	output ket_pkg::seg_t           entry_seg,
	output logic                    hit
);

	ket_pkg::key_t key_q;
	ket_pkg::seg_t seg_q;
	logic          hit_q;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			key_q <= nb_key;
			seg_q <= nb_seg;
		end else if (ctl.wr_new) begin
			key_q <= req_key;
			seg_q <= req_seg;
		end else if (ctl.wr_seg) begin
			seg_q <= req_seg;
		end
	end

	// reads select by slot, the other requests by key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.match_en) begin
			hit_q <= ctl.live & (ctl.by_slot ? ctl.is_slot : (key_q == req_key));
		end
	end

	assign entry_key = key_q;
	assign entry_seg = seg_q;
	assign hit       = hit_q;

endmodule

`default_nettype wire

>>> sv/keyed_entry_table.sv
// sequence: a request runs the match then update sequence over the cell row;
//   hits are registered in S_MATCH, the result is committed in S_EXEC, and a
//   new request is taken only in S_IDLE; a result waiting in the output
//   register holds the update step until it is taken
// reset: arst_n empties the table (live count zero); slot contents are
//   not cleared, no clearing pass
// ------------------------------------------------------------------------
// keyed_entry_table
// packed table of unique keys with segment numbers, compacted on delete
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "keyed_entry_table_assert.svh"

module keyed_entry_table #(
	parameter int DEPTH = 8
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [47:0] s_tdata,  // key[23:0], segment_in[39:24], slot[42:40], zero pad
	input  wire  [2:0]  s_tuser,  // req_type[2:0]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [47:0] m_tdata,  // found_index[2:0], key_out[26:3], segment_out[42:27],
	                              // entry_total[46:43], zero pad
	output logic [2:0]  m_tuser   // status[1:0], found[2]
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (IW > 3) ? IW : 3;
	localparam int TW = (CW > 4) ? CW : 4;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	ket_pkg::state_t state_q, state_d;

	ket_pkg::req_t   req_type_q;
	ket_pkg::key_t   req_key_q;
	ket_pkg::seg_t   req_seg_q;
	logic [2:0]      req_slot_q;
	logic [CW-1:0]   count_q, count_d;

	ket_pkg::key_t      cell_key [DEPTH];
	ket_pkg::seg_t      cell_seg [DEPTH];
	logic [DEPTH-1:0]   hit_q;

	logic            commit;
	logic            any_hit;
	logic [IW-1:0]   pos;
	ket_pkg::key_t   rd_key;
	ket_pkg::seg_t   rd_seg;
	logic            full;

	// decoded result and per-cell write intent
	ket_pkg::stat_t  res_status;
	logic            res_found;
	logic [IW-1:0]   res_index;
	logic            res_rd;
	logic            do_new;
	logic            do_set;
	logic            do_shift;

	logic            out_valid_q;
	ket_pkg::stat_t  out_status_q;
	logic            out_found_q;
	logic [2:0]      out_index_q;
	ket_pkg::key_t   out_key_q;
	ket_pkg::seg_t   out_seg_q;
	logic [3:0]      out_total_q;

	logic [XW-1:0]   index_x;
	logic [TW-1:0]   total_x;

	assign s_tready = (state_q == ket_pkg::S_IDLE);
	assign commit   = (state_q == ket_pkg::S_EXEC) && (!out_valid_q || m_tready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ket_pkg::S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		case (state_q)
			ket_pkg::S_IDLE: begin
				if (s_tvalid) state_d = ket_pkg::S_MATCH;
			end
			ket_pkg::S_MATCH: begin
				state_d = ket_pkg::S_EXEC;
			end
			ket_pkg::S_EXEC: begin
				if (commit) begin
					state_d = ket_pkg::S_IDLE;
					if (do_new) count_d = count_q + CW'(1);
					else if (do_shift) count_d = count_q - CW'(1);
				end
			end
			default: begin
				state_d = ket_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_type_q <= s_tuser;
			req_key_q  <= s_tdata[23:0];
			req_seg_q  <= s_tdata[39:24];
			req_slot_q <= s_tdata[42:40];
		end
	end

	// match line reduction; at most one cell hits
	always_comb begin
		pos    = '0;
		rd_key = '0;
		rd_seg = '0;
		for (int i = 0; i < DEPTH; i++) begin
			pos    = pos | (hit_q[i] ? IW'(i) : '0);
			rd_key = rd_key | (hit_q[i] ? cell_key[i] : '0);
			rd_seg = rd_seg | (hit_q[i] ? cell_seg[i] : '0);
		end
	end

	assign any_hit = |hit_q;
	assign full    = (count_q >= DEPTH_C);

	always_comb begin
		res_status = ket_pkg::STAT_MISS;
		res_found  = 1'b0;
		res_index  = '0;
		res_rd     = 1'b0;
		do_new     = 1'b0;
		do_set     = 1'b0;
		do_shift   = 1'b0;
		case (req_type_q)
			ket_pkg::REQ_ADD: begin
				if (full) begin
					res_status = ket_pkg::STAT_FULL;
				end else if (any_hit) begin
					res_status = ket_pkg::STAT_DUP;
					res_found  = 1'b1;
					res_index  = pos;
				end else begin
					res_status = ket_pkg::STAT_DONE;
					res_found  = 1'b1;
					res_index  = count_q[IW-1:0];
					do_new     = 1'b1;
				end
			end
			ket_pkg::REQ_DELETE: begin
				if (any_hit) begin
					res_status = ket_pkg::STAT_DONE;
					res_found  = 1'b1;
					res_index  = pos;
					do_shift   = 1'b1;
				end
			end
			ket_pkg::REQ_SET: begin
				if (any_hit) begin
					res_status = ket_pkg::STAT_DONE;
					res_found  = 1'b1;
					res_index  = pos;
					do_set     = 1'b1;
				end
			end
			ket_pkg::REQ_LOOKUP: begin
				if (any_hit) begin
					res_status = ket_pkg::STAT_DONE;
					res_found  = 1'b1;
					res_index  = pos;
				end
			end
			ket_pkg::REQ_READ: begin
				if (any_hit) begin
					res_status = ket_pkg::STAT_DONE;
					res_found  = 1'b1;
					res_index  = pos;
					res_rd     = 1'b1;
				end
			end
			default: begin
				res_status = ket_pkg::STAT_MISS;
			end
		endcase
	end

	// cell row
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [CW-1:0] CI  = CW'(i);
		localparam logic [CW-1:0] CI1 = CW'(i + 1);
		localparam logic [IW-1:0] PI  = IW'(i);
		localparam logic [XW-1:0] SI  = XW'(i);

		ket_pkg::key_t      nb_key;
		ket_pkg::seg_t      nb_seg;
		ket_pkg::cell_ctl_t ctl;

		if (i + 1 < DEPTH) begin : g_nb
			assign nb_key = cell_key[i+1];
			assign nb_seg = cell_seg[i+1];
		end else begin : g_top
			assign nb_key = '0;
			assign nb_seg = '0;
		end

		always_comb begin
			ctl.match_en = (state_q == ket_pkg::S_MATCH);
			ctl.by_slot  = (req_type_q == ket_pkg::REQ_READ);
			ctl.live     = (CI < count_q);
			ctl.is_slot  = (XW'(req_slot_q) == SI);
			ctl.wr_new   = commit && do_new && (CI == count_q);
			ctl.wr_seg   = commit && do_set && hit_q[i];
			ctl.shift    = commit && do_shift && (PI >= pos) && (CI1 < count_q);
		end

		ket_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.req_key   (req_key_q),
			.req_seg   (req_seg_q),
			.nb_key    (nb_key),
			.nb_seg    (nb_seg),
			.entry_key (cell_key[i]),
			.entry_seg (cell_seg[i]),
			.hit       (hit_q[i])
		);
	end

	// output register
	assign index_x = XW'(res_index);
	assign total_x = TW'(count_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_status_q <= res_status;
			out_found_q  <= res_found;
			out_index_q  <= index_x[2:0];
			out_key_q    <= res_rd ? rd_key : '0;
			out_seg_q    <= res_rd ? rd_seg : '0;
			out_total_q  <= total_x[3:0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_total_q, out_seg_q, out_key_q, out_index_q};
	assign m_tuser  = {out_found_q, out_status_q};

	`KET_CHECK_NOW(a_count_bound, 1'b1, count_q <= DEPTH_C, "live count above depth")
	`KET_CHECK_NOW(a_single_hit, state_q == ket_pkg::S_EXEC, $onehot0(hit_q),
		"more than one cell matched")
	`KET_CHECK_NEXT(a_accept_to_match, s_tvalid && s_tready, state_q == ket_pkg::S_MATCH,
		"transfer did not start a match")
	`KET_CHECK_NOW(a_full_not_found, out_valid_q && out_status_q == ket_pkg::STAT_FULL,
		!out_found_q, "full result marked found")

endmodule

`default_nettype wire
